>>> rtl/lvhw_pkg.sv
// Package with shared types, constants and fixed-point helpers for the lambda Verlet step.
`timescale 1ns / 1ps
package lvhw_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DwBits   = 2 * WordBits;
  localparam int unsigned CfgIdxBits = 4;

  localparam int unsigned KickLat  = WordBits + 3;
  localparam int unsigned BiasCore = 11;
  localparam int unsigned BiasPad  = KickLat - BiasCore;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [WordBits-2:0]        uword_t;
  typedef logic [DwBits-1:0]          dword_t;
  typedef logic [CfgIdxBits-1:0]      cfg_idx_t;

  localparam logic [1:0] CmdKickDrift = 2'd0;
  localparam logic [1:0] CmdKickWall  = 2'd1;
  localparam logic [1:0] CmdBias      = 2'd2;
  localparam logic [1:0] AxisLambda   = 2'd3;

  localparam cfg_idx_t CfgTimeStep   = cfg_idx_t'(0);
  localparam cfg_idx_t CfgHalfKick   = cfg_idx_t'(1);
  localparam cfg_idx_t CfgHeight     = cfg_idx_t'(2);
  localparam cfg_idx_t CfgBiasEnable = cfg_idx_t'(3);

  localparam uword_t HeightReset = uword_t'(((64'd1 << FracBits) + 64'd5) / 64'd10);

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};
  localparam longint WideMax = (longint'(1) <<< (WordBits - 1)) - 1;
  localparam longint WideMin = -WideMax - 1;
  localparam longint HalfFx  = longint'(1) <<< (FracBits - 1);
  localparam longint OneFx   = longint'(1) <<< FracBits;
  localparam dword_t DwHalf  = dword_t'(1) << (WordBits - 1);
  localparam dword_t DwMax   = DwHalf - dword_t'(1);

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] axis;
    logic       in_group;
    word_t      position;
    word_t      velocity;
    word_t      force_req;
    uword_t     mass;
  } in_item_t;

  typedef struct packed {
    word_t position_out;
    word_t velocity_out;
    word_t force_out;
    logic  lambda_state;
    logic  state_written;
  } out_item_t;

  function automatic word_t sat_wide(longint x);
    word_t r;
    if (x > WideMax) r = WordMax;
    else if (x < WideMin) r = WordMin;
    else r = word_t'(x);
    return r;
  endfunction

  function automatic logic [WordBits-1:0] mag_of(word_t x);
    logic [WordBits-1:0] ux;
    ux = x;
    return x[WordBits-1] ? (~ux + 1'b1) : ux;
  endfunction

  function automatic word_t from_mag(dword_t m, logic neg);
    word_t r;
    if (neg) begin
      if (m > DwHalf) r = WordMin;
      else r = word_t'(~m[WordBits-1:0] + 1'b1);
    end else begin
      if (m > DwMax) r = WordMax;
      else r = word_t'(m[WordBits-1:0]);
    end
    return r;
  endfunction

  function automatic word_t fin_prod(dword_t prod, logic neg);
    return from_mag(prod >> FracBits, neg);
  endfunction

endpackage

>>> rtl/lvhw_kick.sv
// Kick pipeline: force times scale, then a bit-per-stage division by the mass.
`timescale 1ns / 1ps
module lvhw_kick (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  lvhw_pkg::in_item_t item_i,
  input  lvhw_pkg::uword_t   scale_i,
  output logic               valid_o,
  output lvhw_pkg::in_item_t item_o,
  output lvhw_pkg::word_t    kick_o
);

  localparam int unsigned W = lvhw_pkg::WordBits;

  logic               v1_q;
  lvhw_pkg::in_item_t it1_q;
  lvhw_pkg::dword_t   p1_q;

  logic               dval_q  [W+1];
  lvhw_pkg::in_item_t dit_q   [W+1];
  logic [W-1:0]       drem_q  [W+1];
  logic [W-1:0]       dlow_q  [W+1];
  logic [W-1:0]       dquo_q  [W+1];
  logic               dovf_q  [W+1];
  logic               dzero_q [W+1];

  logic [W-1:0]       rem_d   [W+1];
  logic [W-1:0]       quo_d   [W+1];

  logic               vf_q;
  lvhw_pkg::in_item_t itf_q;
  lvhw_pkg::word_t    kick_q;
  lvhw_pkg::word_t    kick_d;

  always_comb begin
    logic [W-1:0] sh;
    logic [W-1:0] dv;
    rem_d[0] = '0;
    quo_d[0] = '0;
    for (int j = 1; j <= W; j++) begin
      sh = {drem_q[j-1][W-2:0], dlow_q[j-1][W-1]};
      dv = {1'b0, dit_q[j-1].mass};
      if (sh >= dv) begin
        rem_d[j] = sh - dv;
        quo_d[j] = {dquo_q[j-1][W-2:0], 1'b1};
      end else begin
        rem_d[j] = sh;
        quo_d[j] = {dquo_q[j-1][W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic neg;
    neg = dit_q[W].force_req[W-1];
    if (dzero_q[W]) kick_d = '0;
    else if (dovf_q[W]) kick_d = neg ? lvhw_pkg::WordMin : lvhw_pkg::WordMax;
    else kick_d = lvhw_pkg::from_mag(lvhw_pkg::dword_t'(dquo_q[W]), neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vf_q <= 1'b0;
      for (int j = 0; j <= W; j++) dval_q[j] <= 1'b0;
    end else if (en_i) begin
      v1_q      <= valid_i;
      dval_q[0] <= v1_q;
      for (int j = 1; j <= W; j++) dval_q[j] <= dval_q[j-1];
      vf_q      <= dval_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q      <= item_i;
      p1_q       <= lvhw_pkg::dword_t'(scale_i) *
                    lvhw_pkg::dword_t'(lvhw_pkg::mag_of(item_i.force_req));
      dit_q[0]   <= it1_q;
      drem_q[0]  <= p1_q[2*W-1:W];
      dlow_q[0]  <= p1_q[W-1:0];
      dquo_q[0]  <= '0;
      dovf_q[0]  <= (p1_q[2*W-1:W] >= {1'b0, it1_q.mass});
      dzero_q[0] <= (p1_q == '0);
      for (int j = 1; j <= W; j++) begin
        dit_q[j]   <= dit_q[j-1];
        drem_q[j]  <= rem_d[j];
        dlow_q[j]  <= {dlow_q[j-1][W-2:0], 1'b0};
        dquo_q[j]  <= quo_d[j];
        dovf_q[j]  <= dovf_q[j-1];
        dzero_q[j] <= dzero_q[j-1];
      end
      itf_q  <= dit_q[W];
      kick_q <= kick_d;
    end
  end

  assign valid_o = vf_q;
  assign item_o  = itf_q;
  assign kick_o  = kick_q;

endmodule

>>> rtl/lvhw_bias.sv
// Bias force pipeline for the lambda variable, delayed to line up with the kick pipeline.
`timescale 1ns / 1ps
module lvhw_bias (
  input  logic             clk_i,
  input  logic             en_i,
  input  lvhw_pkg::word_t  position_i,
  input  lvhw_pkg::word_t  force_i,
  input  lvhw_pkg::uword_t height_i,
  output lvhw_pkg::word_t  force_o
);

  localparam int unsigned W = lvhw_pkg::WordBits;

  lvhw_pkg::word_t  ul_q [7];
  lvhw_pkg::word_t  fl_q [10];
  lvhw_pkg::dword_t pa_q, pb_q, pc_q, pd_q, ph_q;
  logic             na_q, nb_q, nc_q, nd_q, nh_q;
  lvhw_pkg::word_t  u9_q, t1_q, t2_q, t3_q, fb_q;
  lvhw_pkg::word_t  pad_q [lvhw_pkg::BiasPad];
  lvhw_pkg::word_t  u2_c, u4_c, u8_c;

  assign u2_c = lvhw_pkg::fin_prod(pa_q, na_q);
  assign u4_c = lvhw_pkg::fin_prod(pb_q, nb_q);
  assign u8_c = lvhw_pkg::fin_prod(pc_q, nc_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ul_q[0] <= lvhw_pkg::sat_wide(longint'(position_i) - lvhw_pkg::HalfFx);
      for (int k = 1; k < 7; k++) ul_q[k] <= ul_q[k-1];
      fl_q[0] <= force_i;
      for (int k = 1; k < 10; k++) fl_q[k] <= fl_q[k-1];
      pa_q <= lvhw_pkg::dword_t'(lvhw_pkg::mag_of(ul_q[0])) *
              lvhw_pkg::dword_t'(lvhw_pkg::mag_of(ul_q[0]));
      na_q <= 1'b0;
      pb_q <= lvhw_pkg::dword_t'(lvhw_pkg::mag_of(u2_c)) *
              lvhw_pkg::dword_t'(lvhw_pkg::mag_of(u2_c));
      nb_q <= 1'b0;
      pc_q <= lvhw_pkg::dword_t'(lvhw_pkg::mag_of(u4_c)) *
              lvhw_pkg::dword_t'(lvhw_pkg::mag_of(u4_c));
      nc_q <= 1'b0;
      pd_q <= lvhw_pkg::dword_t'(lvhw_pkg::mag_of(u8_c)) *
              lvhw_pkg::dword_t'(lvhw_pkg::mag_of(ul_q[3]));
      nd_q <= u8_c[W-1] ^ ul_q[3][W-1];
      u9_q <= lvhw_pkg::fin_prod(pd_q, nd_q);
      t1_q <= lvhw_pkg::sat_wide(longint'(-7980) * longint'(u9_q));
      t2_q <= lvhw_pkg::sat_wide(longint'(t1_q) + 2 * longint'(ul_q[6]));
      t3_q <= lvhw_pkg::sat_wide(10 * longint'(t2_q));
      ph_q <= lvhw_pkg::dword_t'(lvhw_pkg::mag_of(t3_q)) * lvhw_pkg::dword_t'(height_i);
      nh_q <= t3_q[W-1];
      fb_q <= lvhw_pkg::sat_wide(longint'(fl_q[9]) +
                                 longint'(lvhw_pkg::fin_prod(ph_q, nh_q)));
      pad_q[0] <= fb_q;
      for (int k = 1; k < lvhw_pkg::BiasPad; k++) pad_q[k] <= pad_q[k-1];
    end
  end

  assign force_o = pad_q[lvhw_pkg::BiasPad-1];

endmodule

>>> rtl/lvhw_post.sv
// Post pipeline: velocity update, drift, wall reflection and result selection.
`timescale 1ns / 1ps
module lvhw_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  lvhw_pkg::in_item_t  item_i,
  input  lvhw_pkg::word_t     kick_i,
  input  lvhw_pkg::word_t     force_bias_i,
  input  lvhw_pkg::uword_t    time_step_i,
  input  logic                bias_en_i,
  output logic                valid_o,
  output lvhw_pkg::out_item_t item_o
);

  localparam int unsigned W = lvhw_pkg::WordBits;

  logic                va_q, vb_q, vc_q, vd_q;
  lvhw_pkg::in_item_t  ia_q, ib_q, ic_q;
  lvhw_pkg::word_t     fa_q, fb_q, fc_q;
  lvhw_pkg::word_t     vela_q, velb_q, velc_q;
  lvhw_pkg::dword_t    prb_q;
  logic                nb_q;
  lvhw_pkg::word_t     dc_q;
  lvhw_pkg::out_item_t out_q, out_d;

  always_comb begin
    logic grp, lam;
    lvhw_pkg::word_t pn;
    grp = ic_q.in_group;
    lam = (ic_q.axis == lvhw_pkg::AxisLambda);
    pn  = lvhw_pkg::sat_wide(longint'(ic_q.position) + longint'(dc_q));
    out_d.position_out  = ic_q.position;
    out_d.velocity_out  = ic_q.velocity;
    out_d.force_out     = ic_q.force_req;
    out_d.lambda_state  = 1'b0;
    out_d.state_written = 1'b0;
    if (grp && (ic_q.cmd == lvhw_pkg::CmdKickDrift || ic_q.cmd == lvhw_pkg::CmdKickWall)) begin
      out_d.velocity_out = velc_q;
      if (ic_q.cmd == lvhw_pkg::CmdKickDrift) begin
        out_d.position_out = pn;
        if (lam) begin
          out_d.lambda_state  = (longint'(pn) >= lvhw_pkg::HalfFx);
          out_d.state_written = 1'b1;
        end
      end else if (lam) begin
        if (ic_q.position[W-1]) begin
          out_d.position_out = lvhw_pkg::sat_wide(-longint'(ic_q.position));
          out_d.velocity_out = lvhw_pkg::sat_wide(-longint'(velc_q));
        end else if (longint'(ic_q.position) > lvhw_pkg::OneFx) begin
          out_d.position_out = lvhw_pkg::sat_wide(2 * lvhw_pkg::OneFx -
                                                  longint'(ic_q.position));
          out_d.velocity_out = lvhw_pkg::sat_wide(-longint'(velc_q));
        end
      end
    end else if (grp && ic_q.cmd == lvhw_pkg::CmdBias && lam && bias_en_i) begin
      out_d.force_out = fc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ia_q   <= item_i;
      fa_q   <= force_bias_i;
      vela_q <= lvhw_pkg::sat_wide(longint'(item_i.velocity) + longint'(kick_i));
      ib_q   <= ia_q;
      fb_q   <= fa_q;
      velb_q <= vela_q;
      prb_q  <= lvhw_pkg::dword_t'(time_step_i) *
                lvhw_pkg::dword_t'(lvhw_pkg::mag_of(vela_q));
      nb_q   <= vela_q[W-1];
      ic_q   <= ib_q;
      fc_q   <= fb_q;
      velc_q <= velb_q;
      dc_q   <= lvhw_pkg::fin_prod(prb_q, nb_q);
      out_q  <= out_d;
    end
  end

  assign valid_o = vd_q;
  assign item_o  = out_q;

endmodule

>>> rtl/lambda_verlet_hard_wall_step.sv
// Top level of the lambda velocity-Verlet step with hard walls.
//
// One item carries one coordinate of one particle and yields one result item.
// The input and output channels use valid and ready; configuration registers
// are written through a separate channel that is always ready.
// One item can be accepted every cycle while the output is not stalled.
// The pipeline depth is set by the mass division, which retires one quotient bit
// per pipeline stage, followed by the drift multiply and result selection.
// The bias force runs in a parallel pipeline of the same length as the kick pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and input ready drops; no item is lost or repeated.
// Reset clears all valid bits and sets the registers to their defaults:
// time step, half kick scale and bias enable to zero, barrier height to 0.1.
// Configuration should be written only while no items are in flight.
`timescale 1ns / 1ps
module lambda_verlet_hard_wall_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lvhw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lvhw_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  lvhw_pkg::cfg_idx_t  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  lvhw_pkg::uword_t   time_step_q, half_kick_q, height_q;
  logic               bias_en_q;
  logic               en;
  logic               kvalid;
  lvhw_pkg::in_item_t kitem;
  lvhw_pkg::word_t    kick;
  lvhw_pkg::word_t    fbias;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
      half_kick_q <= '0;
      height_q    <= lvhw_pkg::HeightReset;
      bias_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lvhw_pkg::CfgTimeStep:   time_step_q <= cfg_data_i[30:0];
        lvhw_pkg::CfgHalfKick:   half_kick_q <= cfg_data_i[30:0];
        lvhw_pkg::CfgHeight:     height_q    <= cfg_data_i[30:0];
        lvhw_pkg::CfgBiasEnable: bias_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lvhw_kick u_kick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .scale_i (half_kick_q),
    .valid_o (kvalid),
    .item_o  (kitem),
    .kick_o  (kick)
  );

  lvhw_bias u_bias (
    .clk_i      (clk_i),
    .en_i       (en),
    .position_i (in_item_i.position),
    .force_i    (in_item_i.force_req),
    .height_i   (height_q),
    .force_o    (fbias)
  );

  lvhw_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (kvalid),
    .item_i       (kitem),
    .kick_i       (kick),
    .force_bias_i (fbias),
    .time_step_i  (time_step_q),
    .bias_en_i    (bias_en_q),
    .valid_o      (out_valid_o),
    .item_o       (out_item_o)
  );

  a_state_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.state_written |-> !out_item_o.lambda_state)
    else $error("lambda_state set without state_written");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  a_cfg_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == lvhw_pkg::CfgBiasEnable |=> bias_en_q == $past(cfg_data_i[0]))
    else $error("bias enable write lost");

endmodule

>>> sim/tb_lambda_verlet_hard_wall_step.sv
// Self-checking testbench for the lambda Verlet step: random and directed items with a scoreboard.
`timescale 1ns / 1ps
module tb_lambda_verlet_hard_wall_step;
  import lvhw_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam cfg_idx_t CfgUnused = cfg_idx_t'(9);
  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 45;

  class verlet_scoreboard;
    longint dt;
    longint hk;
    longint height;
    bit bias_on;
    out_item_t pending[$];
    int errors;

    function new();
      dt = 0;
      hk = 0;
      height = longint'(HeightReset);
      bias_on = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CfgTimeStep: dt = longint'(d[30:0]);
        CfgHalfKick: hk = longint'(d[30:0]);
        CfgHeight: height = longint'(d[30:0]);
        CfgBiasEnable: bias_on = d[0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint x);
      if (x > WideMax) return WideMax;
      if (x < WideMin) return WideMin;
      return x;
    endfunction

    function longint signed_of(bit neg, longint m);
      longint lim;
      lim = neg ? WideMax + 1 : WideMax;
      if (m > lim) return neg ? WideMin : WideMax;
      return neg ? -m : m;
    endfunction

    function longint fx_mul(longint a, longint b);
      bit neg;
      longint ma;
      longint mb;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      return signed_of(neg, (ma * mb) >> FracBits);
    endfunction

    function longint kick(longint f, longint m);
      longint prod;
      prod = hk * (f < 0 ? -f : f);
      if (m == 0) begin
        if (prod == 0) return 0;
        return f < 0 ? WideMin : WideMax;
      end
      return signed_of(f < 0, prod / m);
    endfunction

    function longint bias_term(longint lam);
      longint u;
      longint u2;
      longint u4;
      longint u9;
      longint t;
      u = clamp(lam - HalfFx);
      u2 = fx_mul(u, u);
      u4 = fx_mul(u2, u2);
      u9 = fx_mul(fx_mul(u4, u4), u);
      t = clamp(-7980 * u9);
      t = clamp(t + 2 * u);
      t = clamp(t * 10);
      return fx_mul(t, height);
    endfunction

    function void note_input(in_item_t it);
      longint p;
      longint v;
      longint f;
      bit lam;
      out_item_t r;
      p = longint'(it.position);
      v = longint'(it.velocity);
      f = longint'(it.force_req);
      lam = it.axis == AxisLambda;
      r.lambda_state = 0;
      r.state_written = 0;
      if (it.in_group && (it.cmd == CmdKickDrift || it.cmd == CmdKickWall)) begin
        v = clamp(v + kick(f, longint'(it.mass)));
        if (it.cmd == CmdKickDrift) begin
          p = clamp(p + fx_mul(dt, v));
          if (lam) begin
            r.lambda_state = p >= HalfFx;
            r.state_written = 1;
          end
        end else if (lam) begin
          if (p < 0) begin
            p = clamp(-p);
            v = clamp(-v);
          end else if (p > OneFx) begin
            p = clamp(2 * OneFx - p);
            v = clamp(-v);
          end
        end
      end else if (it.in_group && it.cmd == CmdBias && lam && bias_on) begin
        f = clamp(f + bias_term(p));
      end
      r.position_out = word_t'(p);
      r.velocity_out = word_t'(v);
      r.force_out = word_t'(f);
      pending.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", field, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected item", got.position_out, 0);
        return;
      end
      want = pending.pop_front();
      if (got.position_out !== want.position_out)
        report("position_out", got.position_out, want.position_out);
      if (got.velocity_out !== want.velocity_out)
        report("velocity_out", got.velocity_out, want.velocity_out);
      if (got.force_out !== want.force_out)
        report("force_out", got.force_out, want.force_out);
      if (got.lambda_state !== want.lambda_state)
        report("lambda_state", got.lambda_state, want.lambda_state);
      if (got.state_written !== want.state_written)
        report("state_written", got.state_written, want.state_written);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;
  verlet_scoreboard sb = new();

  lambda_verlet_hard_wall_step dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o(out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) begin
    out_ready <= $urandom_range(0, 99) >= recv_idle;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_item);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_regs(logic [31:0] ts, logic [31:0] kick, logic [31:0] h, logic en);
    write_reg(CfgTimeStep, ts);
    write_reg(CfgHalfKick, kick);
    write_reg(CfgHeight, h);
    write_reg(CfgBiasEnable, {31'(0), en});
    cfg_valid <= 0;
  endtask

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] c, logic [1:0] ax, logic g,
                                         longint p, longint v, longint f, longint m);
    in_item_t it;
    it.cmd = c;
    it.axis = ax;
    it.in_group = g;
    it.position = word_t'(p);
    it.velocity = word_t'(v);
    it.force_req = word_t'(f);
    it.mass = uword_t'(m);
    return it;
  endfunction

  function automatic longint rand_word();
    case ($urandom_range(0, 9))
      0: return longint'(signed'($urandom));
      1: return $urandom_range(0, 1) ? WideMax : WideMin;
      default: return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    longint p;
    longint m;
    r = $urandom_range(0, 19);
    it.cmd = r < 8 ? CmdKickDrift : r < 14 ? CmdKickWall : r < 19 ? CmdBias : CmdUnused;
    it.axis = $urandom_range(0, 1) ? AxisLambda : 2'($urandom_range(0, 2));
    it.in_group = $urandom_range(0, 9) != 0;
    if (it.axis == AxisLambda && $urandom_range(0, 4) != 0)
      p = longint'($urandom_range(0, 2 * OneFx)) - HalfFx;
    else
      p = rand_word();
    it.position = word_t'(p);
    it.velocity = word_t'(rand_word());
    it.force_req = word_t'(rand_word());
    case ($urandom_range(0, 19))
      0: m = 0;
      1, 2: m = longint'($urandom);
      default: m = longint'($urandom_range(1 << 14, 1 << 18));
    endcase
    it.mass = uword_t'(m);
    return it;
  endfunction

  initial begin
    longint one;
    one = OneFx;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_item(make_item(CmdBias, AxisLambda, 1, 0, 0, one, one));
    send_item(make_item(CmdKickDrift, AxisLambda, 1, one / 4, one, one, one));
    drain();
    load_regs(32'(one), 32'(one / 2), 32'(HeightReset), 1);
    send_item(make_item(CmdKickDrift, AxisLambda, 1, one / 2 - 1, 0, 0, one));
    send_item(make_item(CmdKickDrift, AxisLambda, 1, one / 2, 0, 0, one));
    send_item(make_item(CmdKickDrift, AxisLambda, 1, one * 2 / 5, one / 5, one, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, -one / 10, one, 0, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, one * 6 / 5, -one, 0, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, 0, one, 0, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, one, -one, 0, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, WideMin, WideMin, 0, one));
    send_item(make_item(CmdKickWall, AxisLambda, 1, WideMax, WideMax, 0, one));
    send_item(make_item(CmdBias, AxisLambda, 1, one / 2, 0, one, one));
    send_item(make_item(CmdBias, AxisLambda, 1, 0, 0, WideMax, one));
    send_item(make_item(CmdBias, AxisLambda, 1, one, 0, WideMin, one));
    send_item(make_item(CmdBias, AxisLambda, 1, WideMax, 0, 0, one));
    send_item(make_item(CmdBias, AxisLambda, 1, WideMin, 0, 0, one));
    send_item(make_item(CmdBias, 2'd1, 1, one / 3, one, one, one));
    send_item(make_item(CmdUnused, AxisLambda, 1, -one, one, one, one));
    send_item(make_item(CmdKickDrift, AxisLambda, 0, -one, one, one, one));
    send_item(make_item(CmdKickDrift, 2'd0, 1, one, one, -one, 0));
    send_item(make_item(CmdKickWall, 2'd2, 1, one, one, 0, 0));
    send_item(make_item(CmdKickDrift, 2'd1, 1, WideMax, WideMax, WideMax, WideMax));
    send_item(make_item(CmdKickDrift, 2'd0, 1, WideMin, WideMin, WideMin, 1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = ph < 2 ? 17 : ph < 4 ? 86 : 0;
      recv_idle = ph < 2 ? 86 : ph < 4 ? 17 : 0;
      case (ph)
        0: load_regs($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17),
                     32'(HeightReset), 1);
        1: load_regs(0, 32'h7fff_ffff, 32'hffff_ffff, 1);
        2: load_regs(32'hffff_ffff, 0, 0, 0);
        3: load_regs($urandom, $urandom, $urandom, 1);
        4: load_regs($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17), $urandom, 0);
        default: begin
          write_reg(CfgUnused, $urandom);
          load_regs($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17),
                    $urandom_range(0, 1 << 20), 1);
        end
      endcase
      repeat (290) send_item(rand_item());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/lvhw_pkg.sv
rtl/lvhw_kick.sv
rtl/lvhw_bias.sv
rtl/lvhw_post.sv
rtl/lambda_verlet_hard_wall_step.sv
sim/tb_lambda_verlet_hard_wall_step.sv
